// ===== design/mma_pkg.sv =====
// Package for the matrix multiply-accumulate block: sizes, operation codes,
// sequencer states and the control struct that drives the MAC unit.
// No dependencies.
package mma_pkg;

  localparam int MAX_DIM     = 8;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int K_W         = $clog2(MAX_DIM + 1);
  localparam int ROW_W       = 3;
  localparam int COL_W       = 3;
  localparam int DATA_W      = 32;
  localparam int SIZE_W      = 4;

  localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RESET = 4'd8;

  typedef enum logic [1:0] {
    OP_WRITE_A   = 2'd0,
    OP_WRITE_B   = 2'd1,
    OP_WRITE_ACC = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic init;
    logic term;
  } mac_ctl_t;

endpackage

// ===== design/mma_if.sv =====
// Valid/ready channel interfaces for the request items and the result items.
// Depends on mma_pkg.
interface mma_req_if;
  logic                         valid;
  logic                         ready;
  mma_pkg::op_t                 operation;
  logic [mma_pkg::ROW_W-1:0]    row;
  logic [mma_pkg::COL_W-1:0]    col;
  logic signed [mma_pkg::DATA_W-1:0] value;

  modport source (output valid, operation, row, col, value, input ready);
  modport sink (input valid, operation, row, col, value, output ready);
endinterface

interface mma_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [mma_pkg::DATA_W-1:0] result_value;

  modport source (output valid, result_value, input ready);
  modport sink (input valid, result_value, output ready);
endinterface

// ===== design/matrix_multiply_accumulate.sv =====
// Top level of the matrix multiply-accumulate block: request decode, the
// sequencer that walks one dot product, the two stores and the result register.
// Depends on mma_pkg, mma_if, mma_ram and mma_mac.
//
//   channel  direction  carries
//   req      sink       operation, row, col, value
//   rsp      source     result_value
//   cfg      write      active_size (cfg_we, cfg_data)
//
// A write item is stored when it is accepted. A read item walks k from zero up to n,
// where n is active_size capped at MAX_DIM, with one read of each store and one
// multiply-accumulate per term; when n is zero only the accumulator entry is read.
// Reset is synchronous and clears control state only; store contents are undefined
// until written. A result waiting in the output register holds the next read in its
// drain state when it finishes, and no request is accepted meanwhile.
module matrix_multiply_accumulate (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [mma_pkg::SIZE_W-1:0] cfg_data,
  mma_req_if.sink                    req,
  mma_rsp_if.source                  rsp
);
  import mma_pkg::*;

  localparam logic [IDX_W-1:0] STRIDE = IDX_W'(MAX_DIM);

  state_t              state, state_next;
  logic [K_W-1:0]      k, k_next;
  logic [SIZE_W-1:0]   active_size;
  logic [ROW_W-1:0]    row_q;
  logic [COL_W-1:0]    col_q;
  logic [K_W-1:0]      n_q;
  logic                in_range_q;
  logic                d_valid;
  logic                rd_valid;
  logic                issue;
  logic                load_out;
  logic                accept;
  logic                in_range;
  logic [K_W-1:0]      n_eff;
  logic [IDX_W-1:0]    req_idx;
  logic [IDX_W-1:0]    a_idx;
  logic [IDX_W-1:0]    b_idx;
  logic                mem0_we;
  logic [IDX_W:0]      mem0_waddr;
  logic [IDX_W:0]      mem0_raddr;
  logic [DATA_W-1:0]   mem0_rdata;
  logic                mem1_we;
  logic [DATA_W-1:0]   mem1_rdata;
  logic [DATA_W-1:0]   init_value;
  logic [DATA_W-1:0]   acc;
  logic                mac_busy;
  mac_ctl_t            mac_ctl;

  assign accept   = req.valid && req.ready;
  assign in_range = (int'(req.row) < MAX_DIM) && (int'(req.col) < MAX_DIM);
  assign req_idx  = IDX_W'(IDX_W'(req.row) * STRIDE + IDX_W'(req.col));
  assign n_eff    = (int'(active_size) > MAX_DIM) ? K_W'(MAX_DIM) : K_W'(active_size);
  assign a_idx    = IDX_W'(IDX_W'(row_q) * STRIDE + IDX_W'(k));
  assign b_idx    = IDX_W'(IDX_W'(k) * STRIDE + IDX_W'(col_q));

  // The first store holds A in its lower half and the accumulator in its upper half.
  assign mem0_we    = accept && in_range &&
                      ((req.operation == OP_WRITE_A) || (req.operation == OP_WRITE_ACC));
  assign mem0_waddr = {req.operation == OP_WRITE_ACC, req_idx};
  assign mem0_raddr = issue ? {1'b0, a_idx} : {1'b1, req_idx};
  assign mem1_we    = accept && in_range && (req.operation == OP_WRITE_B);

  mma_ram #(.DEPTH(2 * STORE_DEPTH), .WIDTH(DATA_W)) u_ad_ram (
    .clk   (clk),
    .we    (mem0_we),
    .waddr (mem0_waddr),
    .wdata (req.value),
    .raddr (mem0_raddr),
    .rdata (mem0_rdata)
  );

  mma_ram #(.DEPTH(STORE_DEPTH), .WIDTH(DATA_W)) u_b_ram (
    .clk   (clk),
    .we    (mem1_we),
    .waddr (req_idx),
    .wdata (req.value),
    .raddr (b_idx),
    .rdata (mem1_rdata)
  );

  assign init_value   = in_range_q ? mem0_rdata : '0;
  assign mac_ctl.init = d_valid;
  assign mac_ctl.term = rd_valid;

  mma_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctl        (mac_ctl),
    .init_value (init_value),
    .a_data     (mem0_rdata),
    .b_data     (mem1_rdata),
    .busy       (mac_busy),
    .acc        (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      k           <= '0;
      d_valid     <= 1'b0;
      rd_valid    <= 1'b0;
      active_size <= ACTIVE_SIZE_RESET;
      rsp.valid   <= 1'b0;
    end else begin
      state    <= state_next;
      k        <= k_next;
      d_valid  <= accept && (req.operation == OP_READ);
      rd_valid <= issue;
      if (cfg_we) begin
        active_size <= cfg_data;
      end
      if (load_out) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_q      <= req.row;
      col_q      <= req.col;
      in_range_q <= in_range;
      n_q        <= in_range ? n_eff : '0;
    end
    if (load_out) begin
      rsp.result_value <= acc;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    issue      = 1'b0;
    load_out   = 1'b0;
    req.ready  = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req.valid && (req.operation == OP_READ)) begin
          state_next = S_RUN;
          k_next     = '0;
        end
      end
      S_RUN: begin
        if (k < n_q) begin
          issue  = 1'b1;
          k_next = k + 1'b1;
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_valid && !mac_busy && (!rsp.valid || rsp.ready)) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/mma_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
module mma_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mma_mac.sv =====
// Multiply-accumulate unit: a registered 32x32 product, then a wrapping add
// into the running sum. Depends on mma_pkg.
module mma_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  mma_pkg::mac_ctl_t             ctl,
  input  logic [mma_pkg::DATA_W-1:0]    init_value,
  input  logic [mma_pkg::DATA_W-1:0]    a_data,
  input  logic [mma_pkg::DATA_W-1:0]    b_data,
  output logic                          busy,
  output logic [mma_pkg::DATA_W-1:0]    acc
);
  import mma_pkg::*;

  logic [DATA_W-1:0]   prod;
  logic                prod_valid;
  logic [DATA_W-1:0]   full_prod;

  assign full_prod = a_data * b_data;
  assign busy      = prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.term;
    end
  end

  always_ff @(posedge clk) begin
    prod <= full_prod;
    if (ctl.init) begin
      acc <= init_value;
    end else if (prod_valid) begin
      acc <= acc + prod;
    end
  end

endmodule

// ===== tb/matrix_multiply_accumulate_tb.sv =====
// Self-checking testbench for matrix_multiply_accumulate: random element writes and result reads
// under varying active sizes, checked against a predictor of D + A*B held in a scoreboard class.
// Depends on mma_pkg, mma_if and the RTL of the block.
module matrix_multiply_accumulate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mma_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 155;
  localparam int PRESSURE_PHASE = 9;

  class mac_scoreboard;
    logic [DATA_W-1:0] a_mem [STORE_DEPTH];
    logic [DATA_W-1:0] b_mem [STORE_DEPTH];
    logic [DATA_W-1:0] d_mem [STORE_DEPTH];
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] expected_sums [$];
    int errors;
    int reported;
    int checked;
    int accepted;

    function new();
      size     = ACTIVE_SIZE_RESET;
      errors   = 0;
      reported = 0;
      checked  = 0;
      accepted = 0;
    endfunction

    function void set_size(logic [SIZE_W-1:0] s);
      size = s;
    endfunction

    function logic [DATA_W-1:0] predict_sum(int unsigned row, int unsigned col);
      int unsigned n;
      logic [DATA_W-1:0] sum;
      logic [DATA_W-1:0] prod;
      n   = (size > MAX_DIM) ? MAX_DIM : size;
      sum = d_mem[row * MAX_DIM + col];
      for (int unsigned k = 0; k < n; k++) begin
        prod = a_mem[row * MAX_DIM + k] * b_mem[k * MAX_DIM + col];
        sum  = sum + prod;
      end
      return sum;
    endfunction

    function void note_request(op_t op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                               logic [DATA_W-1:0] value);
      int unsigned idx;
      idx = int'(row) * MAX_DIM + int'(col);
      accepted++;
      case (op)
        OP_WRITE_A:   a_mem[idx] = value;
        OP_WRITE_B:   b_mem[idx] = value;
        OP_WRITE_ACC: d_mem[idx] = value;
        OP_READ:      expected_sums.push_back(predict_sum(row, col));
        default:      ;
      endcase
    endfunction

    function void check_result(logic [DATA_W-1:0] actual);
      logic [DATA_W-1:0] want;
      if (expected_sums.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("Unexpected result %h with no read outstanding", actual);
        end
        return;
      end
      want = expected_sums.pop_front();
      checked++;
      if (actual !== want) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("result_value mismatch: expected %h, got %h", want, actual);
        end
      end
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_data;

  mma_req_if req ();
  mma_rsp_if rsp ();

  matrix_multiply_accumulate u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp)
  );

  mac_scoreboard sb = new();

  int                send_idle_pct;
  int                recv_idle_pct;
  bit                hold_request;
  int                items_sent;
  int                size_settings;
  logic [SIZE_W-1:0] cur_size;
  bit                a_written [STORE_DEPTH];
  bit                b_written [STORE_DEPTH];
  bit                d_written [STORE_DEPTH];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycles_run;
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("Run stopped at the cycle limit");
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready) sb.check_result(rsp.result_value);
      if (req.valid && req.ready) sb.note_request(req.operation, req.row, req.col, req.value);
    end
  end

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      4:       return $urandom_range(0, 15);
      5:       return 32'hffff_fff0 | $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] extreme(int k);
    case (k % 4)
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      default: return 32'h0000_0000;
    endcase
  endfunction

  task automatic send_item(input op_t op, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input logic [DATA_W-1:0] value);
    int idx;
    idx = int'(row) * MAX_DIM + int'(col);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.row       <= row;
    req.col       <= col;
    req.value     <= value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
    case (op)
      OP_WRITE_A:   a_written[idx] = 1'b1;
      OP_WRITE_B:   b_written[idx] = 1'b1;
      OP_WRITE_ACC: d_written[idx] = 1'b1;
      default:      ;
    endcase
  endtask

  // Every entry that the read touches is written first.
  task automatic issue_read(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    int n;
    n = (cur_size > MAX_DIM) ? MAX_DIM : cur_size;
    if (!d_written[int'(row) * MAX_DIM + int'(col)])
      send_item(OP_WRITE_ACC, row, col, rand_value());
    for (int k = 0; k < n; k++) begin
      if (!a_written[int'(row) * MAX_DIM + k])
        send_item(OP_WRITE_A, row, 3'(k), rand_value());
      if (!b_written[k * MAX_DIM + int'(col)])
        send_item(OP_WRITE_B, 3'(k), col, rand_value());
    end
    send_item(OP_READ, row, col, rand_value());
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] s);
    cfg_we   <= 1'b1;
    cfg_data <= s;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_size = s;
    sb.set_size(s);
    size_settings++;
  endtask

  task automatic run_random(input int target, input int read_pct);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 99) < read_pct)
        issue_read(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      else
        send_item(op_t'($urandom_range(0, 2)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), rand_value());
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] sizes [PHASES];
    sizes = '{4'd15, 4'd8, 4'd1, 4'd3, 4'd0, 4'd5, 4'd2, 4'd8, 4'd7, 4'd4, 4'd9, 4'd6};
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_data      <= '0;
    req.valid     <= 1'b0;
    req.operation <= OP_WRITE_A;
    req.row       <= '0;
    req.col       <= '0;
    req.value     <= '0;
    hold_request  <= 1'b0;
    recv_idle_pct <= 46;
    send_idle_pct = 32;
    items_sent    = 0;
    size_settings = 0;
    cur_size      = ACTIVE_SIZE_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Full-length dot product at the reset size with extreme operands.
    for (int k = 0; k < MAX_DIM; k++) begin
      send_item(OP_WRITE_A, 3'd0, 3'(k), extreme(k));
      send_item(OP_WRITE_B, 3'(k), 3'd0, extreme(k + 1));
    end
    send_item(OP_WRITE_ACC, 3'd0, 3'd0, 32'h7fff_ffff);
    send_item(OP_READ, 3'd0, 3'd0, 32'hffff_ffff);
    settle();

    // A read outside the active size, then an empty dot product.
    set_size(4'd1);
    send_item(OP_WRITE_A, 3'd7, 3'd0, 32'h8000_0000);
    send_item(OP_WRITE_B, 3'd0, 3'd7, 32'hffff_ffff);
    send_item(OP_WRITE_ACC, 3'd7, 3'd7, 32'h8000_0000);
    send_item(OP_READ, 3'd7, 3'd7, 32'h0000_0000);
    settle();
    set_size(4'd0);
    send_item(OP_READ, 3'd0, 3'd0, 32'h0000_0000);
    send_item(OP_READ, 3'd7, 3'd7, 32'h7fff_ffff);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        send_idle_pct = 46;
        recv_idle_pct <= 32;
      end else if (p == 2 * PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      set_size(sizes[p]);
      if (p == PRESSURE_PHASE) begin
        hold_request <= 1'b1;
        run_random(PHASE_ITEMS, 80);
      end else begin
        run_random(PHASE_ITEMS, 40);
      end
      settle();
    end

    $display("Sent %0d request items over %0d size settings; checked %0d results, %0d mismatches.",
             sb.accepted, size_settings, sb.checked, sb.errors);
    $display("Sizes ranged from 0 to 15 and one %0d-cycle output hold backed up the input.",
             HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
